>>> hw/rtl/lphm_pkg.sv
`timescale 1ns / 1ps

package lphm_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [6:0] MODULUS_RESET = 7'd61;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
    logic [6:0]         live_entries;
  } rsp_t;

endpackage

>>> hw/rtl/lphm_in_if.sv
`timescale 1ns / 1ps

interface lphm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, cmd, key, value, input ready);
  modport sink   (input valid, cmd, key, value, output ready);
endinterface

>>> hw/rtl/lphm_out_if.sv
`timescale 1ns / 1ps

interface lphm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_value;
  logic [6:0]         live_entries;

  modport source (output valid, status, found_value, live_entries, input ready);
  modport sink   (input valid, status, found_value, live_entries, output ready);
endinterface

>>> hw/rtl/lphm_cfg_if.sv
`timescale 1ns / 1ps

interface lphm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] hash_modulus;

  modport source (output valid, hash_modulus, input ready);
  modport sink   (input valid, hash_modulus, output ready);
endinterface

>>> hw/rtl/lphm_ram.sv
`timescale 1ns / 1ps

module lphm_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/lphm_queue.sv
`timescale 1ns / 1ps

module lphm_queue #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_word
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end

endmodule

>>> hw/rtl/lphm_front.sv
`timescale 1ns / 1ps

module lphm_front import lphm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clearing,
  input  logic [6:0]       hash_modulus,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_req,
  output logic             q_valid,
  input  logic             q_ready,
  output req_t             q_req,
  output logic [IDX_W-1:0] q_home
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_RED  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  // remainder is below 128, so only a smaller depth needs a reduction step
  localparam logic [7:0] RED_LIM = (TABLE_DEPTH < 128) ? 8'(TABLE_DEPTH) : 8'd128;

  logic [1:0]  state_r, state_nxt;
  req_t        req_r, req_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [6:0]  mod_r, mod_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  trial;
  logic        trial_ge;

  assign trial    = {rem_r, mag_r[31]};
  assign trial_ge = (trial >= {1'b0, mod_r});

  assign in_ready = (state_r == F_IDLE) && !clearing;
  assign q_valid  = (state_r == F_PUSH);
  assign q_req    = req_r;
  assign q_home   = IDX_W'(rem_r);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    mag_nxt     = mag_r;
    mod_nxt     = mod_r;
    rem_nxt     = rem_r;
    bit_cnt_nxt = bit_cnt_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt     = in_req;
          // two's complement negate also maps the most negative key to 2^31
          mag_nxt     = in_req.key[31] ? (32'd0 - $unsigned(in_req.key))
                                       : $unsigned(in_req.key);
          mod_nxt     = (hash_modulus == 7'd0) ? 7'd1 : hash_modulus;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt     = trial_ge ? 7'(trial - {1'b0, mod_r}) : trial[6:0];
        mag_nxt     = {mag_r[30:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == 5'd31) begin
          state_nxt = F_RED;
        end
      end
      F_RED: begin
        if ({1'b0, rem_r} >= RED_LIM) begin
          rem_nxt = rem_r - RED_LIM[6:0];
        end else begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    mag_r     <= mag_nxt;
    mod_r     <= mod_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
  end

endmodule

>>> hw/rtl/lphm_back.sv
`timescale 1ns / 1ps

module lphm_back import lphm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  output logic             clearing,
  input  logic             q_valid,
  output logic             q_ready,
  input  req_t             q_req,
  input  logic [IDX_W-1:0] q_home,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_rsp
);

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  req_t             req_r, req_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0] chk_cnt_r, chk_cnt_nxt;
  logic             have_tomb_r, have_tomb_nxt;
  logic [IDX_W-1:0] tomb_r, tomb_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  slot_t             wr_slot, rd_slot;
  logic [SLOT_W-1:0] rd_word;

  logic             hit, empty, last, probe_end, tomb_eff;
  logic [IDX_W-1:0] tomb_idx_eff;

  lphm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_slot = slot_t'(rd_word);

  // rd_slot belongs to chk_idx_r in every probe cycle
  assign hit          = (rd_slot.state == SLOT_USED) && (rd_slot.key == $unsigned(req_r.key));
  assign empty        = (rd_slot.state == SLOT_EMPTY);
  assign last         = (chk_cnt_r == LAST_IDX);
  assign probe_end    = hit || empty || last;
  assign tomb_eff     = have_tomb_r || (rd_slot.state == SLOT_DELETED);
  assign tomb_idx_eff = have_tomb_r ? tomb_r : chk_idx_r;

  assign clearing  = (state_r == B_CLEAR);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_cnt_nxt   = chk_cnt_r;
    have_tomb_nxt = have_tomb_r;
    tomb_nxt      = tomb_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    q_ready       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = chk_idx_r;
    wr_slot       = '{state: SLOT_USED, key: $unsigned(req_r.key),
                      value: $unsigned(req_r.value)};
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;
    case (state_r)
      B_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_slot     = '{state: SLOT_EMPTY, key: '0, value: '0};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        // start only with a free output register, so a finish never stalls
        q_ready = !out_valid_r;
        if (q_valid && !out_valid_r) begin
          req_nxt = q_req;
          if (q_req.cmd == CMD_NONE) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: STATUS_OK, found_value: '0,
                              live_entries: 7'(count_r)};
          end else begin
            rd_en         = 1'b1;
            rd_addr       = q_home;
            rd_idx_nxt    = wrap_inc(q_home);
            chk_idx_nxt   = q_home;
            chk_cnt_nxt   = '0;
            have_tomb_nxt = 1'b0;
            state_nxt     = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        // read one slot ahead while checking the current one
        rd_en       = 1'b1;
        rd_idx_nxt  = wrap_inc(rd_idx_r);
        chk_idx_nxt = rd_idx_r;
        chk_cnt_nxt = chk_cnt_r + 1'b1;
        if (probe_end) begin
          state_nxt     = B_IDLE;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{status: STATUS_OK, found_value: '0,
                            live_entries: 7'(count_r)};
          case (req_r.cmd)
            CMD_INSERT: begin
              if (hit) begin
                wr_en = 1'b1;
              end else if (empty || tomb_eff) begin
                wr_en     = 1'b1;
                wr_addr   = tomb_eff ? tomb_idx_eff : chk_idx_r;
                count_nxt = count_r + 1'b1;
              end else begin
                out_rsp_nxt.status = STATUS_FULL;
              end
            end
            CMD_LOOKUP: begin
              if (hit) begin
                out_rsp_nxt.found_value = $signed(rd_slot.value);
              end else begin
                out_rsp_nxt.status = STATUS_NOT_FOUND;
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                wr_en   = 1'b1;
                wr_slot = '{state: SLOT_DELETED, key: rd_slot.key, value: '0};
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
              end else begin
                out_rsp_nxt.status = STATUS_NOT_FOUND;
              end
            end
            default: begin
              out_rsp_nxt.status = STATUS_OK;
            end
          endcase
          out_rsp_nxt.live_entries = 7'(count_nxt);
        end else begin
          have_tomb_nxt = tomb_eff;
          tomb_nxt      = tomb_idx_eff;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    chk_cnt_r   <= chk_cnt_nxt;
    have_tomb_r <= have_tomb_nxt;
    tomb_r      <= tomb_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

endmodule

>>> hw/rtl/linear_probe_hash_map.sv
`timescale 1ns / 1ps
// Front: 32-step bit-serial modulo, plus reduction steps when TABLE_DEPTH is below 128;
// back: linear probing, one slot memory read per cycle, result registered.
// The front takes no new word until it has pushed the current one into the queue;
// the back takes no new word while probing or while its result waits in the output register.
// Reset: clearing pass over the slot memory with in_ch.ready low;
// entry count cleared, hash_modulus reset to 61.

module linear_probe_hash_map import lphm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input logic clk,
  input logic rst_n,
  lphm_in_if.sink    in_ch,
  lphm_out_if.source out_ch,
  lphm_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int QW    = $bits(req_t) + IDX_W;

  logic [6:0]       hash_modulus_r, hash_modulus_nxt;
  logic             clearing;
  req_t             in_req, f_req, b_req;
  logic [IDX_W-1:0] f_home, b_home;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0]    f_word, b_word;
  rsp_t             rsp;

  assign cfg_ch.ready     = 1'b1;
  assign hash_modulus_nxt = (cfg_ch.valid) ? cfg_ch.hash_modulus : hash_modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_modulus_r <= MODULUS_RESET;
    end else begin
      hash_modulus_r <= hash_modulus_nxt;
    end
  end

  assign in_req = '{cmd: in_ch.cmd, key: in_ch.key, value: in_ch.value};

  lphm_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .clearing     (clearing),
    .hash_modulus (hash_modulus_r),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_req       (in_req),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_req        (f_req),
    .q_home       (f_home)
  );

  assign f_word = {f_req, f_home};

  lphm_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_word  (b_word)
  );

  assign b_req  = req_t'(b_word[QW-1:IDX_W]);
  assign b_home = b_word[IDX_W-1:0];

  lphm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_req     (b_req),
    .q_home    (b_home),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rsp   (rsp)
  );

  assign out_ch.status       = rsp.status;
  assign out_ch.found_value  = rsp.found_value;
  assign out_ch.live_entries = rsp.live_entries;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_ch.ready
  ) else $error("input ready during slot memory clear");

  a_front_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (in_ch.valid && in_ch.ready) |=> !in_ch.ready
  ) else $error("front took a second word while hashing");

  a_failed_op_zero_value: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_ch.valid && out_ch.status != STATUS_OK) |-> (out_ch.found_value == '0)
  ) else $error("nonzero found_value on a failed operation");

endmodule
